[rtl/core/lzwd_pkg.sv]
// ----------------------------------------------------------------------------
// lzwd_pkg
// Shared constants, codes and beat types of the LZW decoder.
// ----------------------------------------------------------------------------
package lzwd_pkg;

   // Dictionary address width by default
   localparam int TABLE_BITS_DEF = 14;

   localparam int CLEAR_CODE  = 256;
   localparam int START_WIDTH = 9;
   localparam int BUF_W       = 24;
   localparam int LEN_W       = 31;

   // Operation codes
   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_PULL = 1'b1;

   // Response status codes
   localparam logic [2:0] STAT_TAKEN    = 3'd0;
   localparam logic [2:0] STAT_REFUSED  = 3'd1;
   localparam logic [2:0] STAT_ERROR    = 3'd2;
   localparam logic [2:0] STAT_BYTE     = 3'd3;
   localparam logic [2:0] STAT_NONE     = 3'd4;
   localparam logic [2:0] STAT_FINISHED = 3'd5;

   // Register indexes
   localparam logic [1:0] REG_MAX_BITS   = 2'd0;
   localparam logic [1:0] REG_BLOCK_MODE = 2'd1;
   localparam logic [1:0] REG_OUT_LEN    = 2'd2;

   typedef struct packed {
      logic       is_pull;
      logic [7:0] data_byte;
   } req_item_type;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] out_byte;
      logic       end_of_string;
   } rsp_item_type;

   typedef struct packed {
      logic             valid;
      logic [1:0]       index;
      logic [LEN_W-1:0] data;
   } csr_wr_type;

endpackage

[rtl/core/lzwd_req_if.sv]
// ----------------------------------------------------------------------------
// lzwd_req_if
// Request channel: one push or pull operation per beat.
// ----------------------------------------------------------------------------
interface lzwd_req_if;
   logic       valid;
   logic       ready;
   logic       opcode;
   logic [7:0] data_byte;

   modport source (output valid, opcode, data_byte, input ready);
   modport sink   (input valid, opcode, data_byte, output ready);
endinterface

[rtl/core/lzwd_rsp_if.sv]
// ----------------------------------------------------------------------------
// lzwd_rsp_if
// Response channel: one status beat per request.
// ----------------------------------------------------------------------------
interface lzwd_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status;
   logic [7:0] out_byte;
   logic       end_of_string;

   modport source (output valid, status, out_byte, end_of_string, input ready);
   modport sink   (input valid, status, out_byte, end_of_string, output ready);
endinterface

[rtl/core/lzwd_csr_if.sv]
// ----------------------------------------------------------------------------
// lzwd_csr_if
// Configuration write channel: register index and write data per beat.
// ----------------------------------------------------------------------------
interface lzwd_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [30:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/lzwd_front.sv]
// ----------------------------------------------------------------------------
// lzwd_front
// Request front end: classifies each beat and holds it in a two-entry queue.
// ----------------------------------------------------------------------------
module lzwd_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic                  in_opcode,
   input  logic [7:0]            in_data,
   output logic                  item_valid,
   output lzwd_pkg::req_item_type item,
   input  logic                  item_pop
);
   import lzwd_pkg::*;

   req_item_type slot_ff [2];
   req_item_type slot_in [2];
   logic [1:0]   count_ff, count_in;
   logic         push;

   assign in_ready   = (count_ff != 2'd2);
   assign push       = in_valid && in_ready;
   assign item_valid = (count_ff != 2'd0);
   assign item       = slot_ff[0];

   // Shift out on pop, append on push
   always_comb begin
      slot_in[0] = slot_ff[0];
      slot_in[1] = slot_ff[1];
      count_in   = count_ff;
      if (item_pop && item_valid) begin
         slot_in[0] = slot_ff[1];
         count_in   = count_in - 2'd1;
      end
      if (push) begin
         if (count_in == 2'd0) begin
            slot_in[0].is_pull   = (in_opcode == OP_PULL);
            slot_in[0].data_byte = in_data;
         end else begin
            slot_in[1].is_pull   = (in_opcode == OP_PULL);
            slot_in[1].data_byte = in_data;
         end
         count_in = count_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff[0] <= slot_in[0];
      slot_ff[1] <= slot_in[1];
   end

endmodule

[rtl/core/lzwd_back.sv]
// ----------------------------------------------------------------------------
// lzwd_back
// Decode engine: bit unpacking, dictionary, chain walk, output stack, result.
// ----------------------------------------------------------------------------
module lzwd_back #(
   parameter int TABLE_BITS = lzwd_pkg::TABLE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   item_valid,
   input  lzwd_pkg::req_item_type item,
   output logic                   item_pop,
   input  lzwd_pkg::csr_wr_type   csr,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output lzwd_pkg::rsp_item_type rsp
);
   import lzwd_pkg::*;

   localparam int TB    = TABLE_BITS;
   localparam int DEPTH = 1 << TB;
   localparam int CW_W  = $clog2(TB + 1);
   localparam int NF_W  = TB + 1;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_WALK = 3'd1;
   localparam logic [2:0] ST_WAIT = 3'd2;
   localparam logic [2:0] ST_PULL = 3'd3;

   // Memories
   logic [TB-1:0] par_mem [DEPTH];
   logic [7:0]    chr_mem [DEPTH];
   logic [7:0]    stk_mem [DEPTH];

   logic          dict_we, stk_we;
   logic [TB-1:0] dict_waddr, dict_raddr, stk_waddr, stk_raddr;
   logic [TB-1:0] dict_wpar, dict_rpar;
   logic [7:0]    dict_wchr, dict_rchr, stk_wdata, stk_rdata;

   // Control state
   logic [2:0]       state_ff, state_in;
   logic [3:0]       mcb_ff, mcb_in;
   logic             bm_ff, bm_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [NF_W-1:0]  cnt_ff, cnt_in;
   logic [NF_W-1:0]  nf_ff, nf_in;
   logic [TB-1:0]    prev_ff, prev_in;
   logic             pv_ff, pv_in;
   logic [CW_W-1:0]  cw_ff, cw_in;
   logic [BUF_W-1:0] buf_ff, buf_in;
   logic [4:0]       bc_ff, bc_in;
   logic [2:0]       cc_ff, cc_in;
   logic [6:0]       skip_ff, skip_in;
   logic [LEN_W-1:0] em_ff, em_in;
   logic             err_ff, err_in;
   logic             add_ff, add_in;
   logic             rv_ff, rv_in;

   // Payload state
   logic [TB-1:0]    cur_ff, cur_in;
   logic [NF_W-1:0]  n_ff, n_in;
   logic [TB-1:0]    par_ff, par_in;
   logic [7:0]       first_ff, first_in;
   logic             eos_ff, eos_in;
   rsp_item_type     rd_ff, rd_in;

   // Combinational helpers
   logic [4:0]       mcb_ext, clamp;
   logic [NF_W-1:0]  limit, nf_plus, cnt_dec;
   logic [CW_W-1:0]  cw_grow;
   logic             fin;
   logic [BUF_W-1:0] b1, b2, b3, mask;
   logic [4:0]       bc1, bc2, bc3, cw5;
   logic [6:0]       take, skip2;
   logic             have_code;
   logic [TB-1:0]    code;
   logic [2:0]       cc_new;
   logic [LEN_W-1:0] em_inc;

   // Limit from clamped width
   always_comb begin
      mcb_ext = {1'b0, mcb_ff};
      if (mcb_ext < 5'(START_WIDTH)) begin
         clamp = 5'(START_WIDTH);
      end else if (mcb_ext > 5'(TB)) begin
         clamp = 5'(TB);
      end else begin
         clamp = mcb_ext;
      end
      limit   = NF_W'(1) << clamp;
      nf_plus = nf_ff + NF_W'(1);
      cw_grow = ((nf_plus < limit) && ((nf_plus & (nf_plus - NF_W'(1))) == '0))
                ? cw_ff + CW_W'(1) : cw_ff;
      fin     = (em_ff >= len_ff);
      cnt_dec = cnt_ff - NF_W'(1);
      em_inc  = em_ff + LEN_W'(1);
   end

   // Unpack bits of a pushed byte
   always_comb begin
      cw5   = 5'(cw_ff);
      b1    = buf_ff | (BUF_W'(item.data_byte) << bc_ff);
      bc1   = bc_ff + 5'd8;
      take  = (skip_ff < 7'(bc1)) ? skip_ff : 7'(bc1);
      b2    = b1 >> take;
      bc2   = bc1 - 5'(take);
      skip2 = skip_ff - take;
      have_code = (skip2 == 7'd0) && (bc2 >= cw5);
      mask  = ~({BUF_W{1'b1}} << cw5);
      code  = TB'(b2 & mask);
      b3    = b2 >> cw5;
      bc3   = bc2 - cw5;
      cc_new = cc_ff + 3'd1;
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      mcb_in = mcb_ff; bm_in = bm_ff; len_in = len_ff;
      cnt_in = cnt_ff; nf_in = nf_ff; prev_in = prev_ff; pv_in = pv_ff;
      cw_in = cw_ff; buf_in = buf_ff; bc_in = bc_ff; cc_in = cc_ff;
      skip_in = skip_ff; em_in = em_ff; err_in = err_ff; add_in = add_ff;
      cur_in = cur_ff; n_in = n_ff; par_in = par_ff; first_in = first_ff;
      eos_in = eos_ff; rd_in = rd_ff;
      rv_in = rv_ff && !rsp_ready;
      item_pop = 1'b0;
      dict_we = 1'b0; dict_waddr = nf_ff[TB-1:0];
      dict_wpar = prev_ff; dict_wchr = first_ff;
      dict_raddr = cur_ff;
      stk_we = 1'b0; stk_waddr = n_ff[TB-1:0]; stk_wdata = cur_ff[7:0];
      stk_raddr = cnt_dec[TB-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid && !rv_ff) begin
               item_pop = 1'b1;
               rd_in.status = STAT_TAKEN;
               rd_in.out_byte = 8'd0;
               rd_in.end_of_string = 1'b0;
               if (item.is_pull) begin
                  if ((cnt_ff != '0) && !fin) begin
                     em_in  = em_inc;
                     cnt_in = (em_inc >= len_ff) ? '0 : cnt_dec;
                     eos_in = (em_inc >= len_ff) || (cnt_dec == '0);
                     state_in = ST_PULL;
                  end else begin
                     if (fin) begin
                        cnt_in = '0;
                     end
                     rd_in.status = err_ff ? STAT_ERROR : (fin ? STAT_FINISHED : STAT_NONE);
                     rv_in = 1'b1;
                  end
               end else if (err_ff) begin
                  rd_in.status = STAT_ERROR; rv_in = 1'b1;
               end else if (fin) begin
                  rd_in.status = STAT_FINISHED; rv_in = 1'b1;
               end else if (cnt_ff != '0) begin
                  rd_in.status = STAT_REFUSED; rv_in = 1'b1;
               end else begin
                  rv_in = 1'b1;
                  buf_in = b2; bc_in = bc2; skip_in = skip2;
                  if (have_code) begin
                     buf_in = b3; bc_in = bc3; cc_in = cc_new;
                     cur_in = code; n_in = '0; add_in = 1'b0;
                     if (bm_ff && (code == TB'(CLEAR_CODE))) begin
                        // Clear: skip rest of the group of eight
                        if (cc_new != 3'd0) begin
                           skip_in = 7'(cw_ff) * (7'd8 - 7'(cc_new));
                        end
                        nf_in = NF_W'(CLEAR_CODE) + NF_W'(bm_ff);
                        pv_in = 1'b0; prev_in = '0;
                        cw_in = CW_W'(START_WIDTH); cc_in = 3'd0;
                     end else if (!pv_ff) begin
                        if (NF_W'(code) >= nf_ff) begin
                           err_in = 1'b1;
                        end else begin
                           pv_in = 1'b1; prev_in = code;
                           rv_in = 1'b0; state_in = ST_WALK;
                        end
                     end else if (NF_W'(code) < nf_ff) begin
                        add_in = (nf_ff < limit); par_in = prev_ff;
                        prev_in = code; rv_in = 1'b0; state_in = ST_WALK;
                     end else if ((NF_W'(code) == nf_ff) && (nf_ff < limit)) begin
                        // Code not yet defined: add its entry before the walk
                        dict_we = 1'b1;
                        nf_in = nf_plus; cw_in = cw_grow;
                        prev_in = code; rv_in = 1'b0; state_in = ST_WALK;
                     end else begin
                        err_in = 1'b1;
                     end
                  end
               end
            end
         end
         ST_WALK: begin
            if (cur_ff < TB'(CLEAR_CODE)) begin
               // Root reached: stack it and add the deferred entry
               stk_we = 1'b1;
               cnt_in = n_ff + NF_W'(1);
               first_in = cur_ff[7:0];
               if (add_ff) begin
                  dict_we = 1'b1; dict_wpar = par_ff; dict_wchr = cur_ff[7:0];
                  nf_in = nf_plus; cw_in = cw_grow;
               end
               rd_in.status = STAT_TAKEN;
               rd_in.out_byte = 8'd0;
               rd_in.end_of_string = 1'b0;
               rv_in = 1'b1;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            stk_we = 1'b1; stk_wdata = dict_rchr;
            n_in = n_ff + NF_W'(1);
            cur_in = dict_rpar;
            state_in = ST_WALK;
         end
         ST_PULL: begin
            rd_in.status = STAT_BYTE;
            rd_in.out_byte = stk_rdata;
            rd_in.end_of_string = eos_ff;
            rv_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Configuration writes; width and mode changes restart the stream
      if (csr.valid) begin
         case (csr.index)
            REG_MAX_BITS:   mcb_in = csr.data[3:0];
            REG_BLOCK_MODE: bm_in  = csr.data[0];
            REG_OUT_LEN:    len_in = csr.data;
            default:        ;
         endcase
         if ((csr.index == REG_MAX_BITS) || (csr.index == REG_BLOCK_MODE)) begin
            cnt_in = '0; buf_in = '0; bc_in = '0; cc_in = '0; skip_in = '0;
            em_in = '0; err_in = 1'b0; pv_in = 1'b0; prev_in = '0;
            cw_in = CW_W'(START_WIDTH);
            nf_in = NF_W'(CLEAR_CODE) + NF_W'(bm_in);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mcb_ff <= 4'd14; bm_ff <= 1'b1; len_ff <= '0;
         cnt_ff <= '0; nf_ff <= NF_W'(CLEAR_CODE + 1); prev_ff <= '0;
         pv_ff <= 1'b0; cw_ff <= CW_W'(START_WIDTH); buf_ff <= '0;
         bc_ff <= '0; cc_ff <= '0; skip_ff <= '0; em_ff <= '0;
         err_ff <= 1'b0; add_ff <= 1'b0; rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         mcb_ff <= mcb_in; bm_ff <= bm_in; len_ff <= len_in;
         cnt_ff <= cnt_in; nf_ff <= nf_in; prev_ff <= prev_in;
         pv_ff <= pv_in; cw_ff <= cw_in; buf_ff <= buf_in;
         bc_ff <= bc_in; cc_ff <= cc_in; skip_ff <= skip_in; em_ff <= em_in;
         err_ff <= err_in; add_ff <= add_in; rv_ff <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in; n_ff <= n_in; par_ff <= par_in;
      first_ff <= first_in; eos_ff <= eos_in; rd_ff <= rd_in;
   end

   // Dictionary memory
   always_ff @(posedge clock) begin
      if (dict_we) begin
         par_mem[dict_waddr] <= dict_wpar;
         chr_mem[dict_waddr] <= dict_wchr;
      end
      dict_rpar <= par_mem[dict_raddr];
      dict_rchr <= chr_mem[dict_raddr];
   end

   // Output stack memory
   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[stk_waddr] <= stk_wdata;
      end
      stk_rdata <= stk_mem[stk_raddr];
   end

   assign rsp_valid = rv_ff;
   assign rsp       = rd_ff;

endmodule

[rtl/core/lzw_compress_decoder_core.sv]
// ----------------------------------------------------------------------------
// lzw_compress_decoder_core
// Unix-compress LZW decoder with byte push and byte pull requests.
// ----------------------------------------------------------------------------
// Every request beat gets exactly one response beat. Requests enter a
// two-entry queue and are served one at a time by the decode engine. A
// refused, error or status-only request is answered from the idle state; a
// push that completes a code walks the parent chain of the decoded string,
// with a dictionary read in each step of the walk; a pull reads its byte
// through the registered read of the output stack. The
// configuration channel is always ready; write it only while no request is
// outstanding. A write of the width or mode register restarts the stream.
module lzw_compress_decoder_core #(
   parameter int TABLE_BITS = lzwd_pkg::TABLE_BITS_DEF
) (
   input logic       clock,
   input logic       reset,
   lzwd_req_if.sink  req_ch,
   lzwd_rsp_if.source rsp_ch,
   lzwd_csr_if.sink  csr_ch
);
   import lzwd_pkg::*;

   req_item_type item;
   rsp_item_type rsp;
   csr_wr_type   csr;
   logic         item_valid, item_pop;

   assign csr_ch.ready = 1'b1;
   assign csr.valid    = csr_ch.valid;
   assign csr.index    = csr_ch.index;
   assign csr.data     = csr_ch.data;

   lzwd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_ch.valid),
      .in_ready   (req_ch.ready),
      .in_opcode  (req_ch.opcode),
      .in_data    (req_ch.data_byte),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop)
   );

   lzwd_back #(.TABLE_BITS(TABLE_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .csr        (csr),
      .rsp_valid  (rsp_ch.valid),
      .rsp_ready  (rsp_ch.ready),
      .rsp        (rsp)
   );

   assign rsp_ch.status        = rsp.status;
   assign rsp_ch.out_byte      = rsp.out_byte;
   assign rsp_ch.end_of_string = rsp.end_of_string;

endmodule

[rtl/core/lzwd_checker.sv]
// ----------------------------------------------------------------------------
// lzwd_checker
// Port-level checks on the response channel of the decoder.
// ----------------------------------------------------------------------------
module lzwd_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] status,
   input logic [7:0] out_byte,
   input logic       end_of_string
);
   import lzwd_pkg::*;

   // Status stays within its code set
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (status <= STAT_FINISHED))
      else $error("status code out of range");

   // Only a byte beat carries data
   a_quiet_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (status != STAT_BYTE)) |-> ((out_byte == 8'd0) && !end_of_string))
      else $error("payload set on a status-only beat");

   // No response straight after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response shown after reset");

   // Stalled beat holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(status) && $stable(out_byte)))
      else $error("stalled response changed");

endmodule

bind lzw_compress_decoder_core lzwd_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .status        (rsp_ch.status),
   .out_byte      (rsp_ch.out_byte),
   .end_of_string (rsp_ch.end_of_string)
);

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the LZW decoder core: directed table, then encoded
// LZW streams with random content and raw byte runs, checked against a behavioural predictor.
// ----------------------------------------------------------------------------
module tb;
   import lzwd_pkg::*;

   localparam int DSIZE     = 1 << TABLE_BITS_DEF;
   localparam int DMASK     = DSIZE - 1;
   localparam int N_ITEMS   = 1550;
   localparam int CYC_LIMIT = 1000000;
   localparam logic [30:0] LEN_MAX = 31'h7FFFFFFF;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lzwd_req_if req_ch ();
   lzwd_rsp_if rsp_ch ();
   lzwd_csr_if csr_ch ();

   lzw_compress_decoder_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Predictor state
   int unsigned cfg_bits, cfg_block, cfg_len;
   logic [13:0] dict_parent [DSIZE];
   logic [7:0]  dict_char   [DSIZE];
   logic [7:0]  pend_stack  [DSIZE];
   int unsigned pend_count, free_code, last_code, code_w;
   int unsigned bitbuf, bitcnt, group_pos, pad_bits, emitted;
   bit          last_ok, sticky_err;

   rsp_item_type rsp_expected [$];
   int unsigned  n_items, n_beats, n_bytes_out, n_cfg, n_streams, n_fail;
   int unsigned  cycles;
   bit           quiet;

   function automatic int unsigned table_limit();
      int unsigned b;
      b = cfg_bits;
      if (b < START_WIDTH) b = START_WIDTH;
      if (b > TABLE_BITS_DEF) b = TABLE_BITS_DEF;
      return 1 << b;
   endfunction

   function automatic void dict_reset();
      free_code = CLEAR_CODE + cfg_block;
      last_ok   = 1'b0;
      last_code = 0;
      code_w    = START_WIDTH;
   endfunction

   function automatic void stream_restart();
      dict_reset();
      pend_count = 0; bitbuf = 0; bitcnt = 0;
      group_pos = 0; pad_bits = 0; emitted = 0; sticky_err = 1'b0;
   endfunction

   function automatic void apply_csr(logic [1:0] idx, logic [30:0] val);
      case (idx)
         REG_MAX_BITS: begin
            cfg_bits = val[3:0];
            stream_restart();
         end
         REG_BLOCK_MODE: begin
            cfg_block = val[0];
            stream_restart();
         end
         REG_OUT_LEN: cfg_len = val;
         default: ;
      endcase
   endfunction

   function automatic logic [7:0] root_char(int unsigned c);
      c &= DMASK;
      while (c >= CLEAR_CODE) c = dict_parent[c];
      return c[7:0];
   endfunction

   function automatic void load_string(int unsigned c);
      int unsigned n;
      n = 0;
      c &= DMASK;
      while (c >= CLEAR_CODE) begin
         pend_stack[n] = dict_char[c];
         n++;
         c = dict_parent[c];
      end
      pend_stack[n] = c[7:0];
      pend_count = n + 1;
   endfunction

   function automatic void take_code(int unsigned c);
      int unsigned lim;
      logic [7:0]  tail;
      lim = table_limit();
      group_pos = (group_pos + 1) & 7;
      if (cfg_block != 0 && c == CLEAR_CODE) begin
         if (group_pos != 0) pad_bits = code_w * (8 - group_pos);
         dict_reset();
         group_pos = 0;
         return;
      end
      if (!last_ok) begin
         if (c >= free_code) begin
            sticky_err = 1'b1;
            return;
         end
         last_code = c;
         last_ok   = 1'b1;
         load_string(c);
         return;
      end
      if (c < free_code) tail = root_char(c);
      else if (c == free_code && free_code < lim) tail = root_char(last_code);
      else begin
         sticky_err = 1'b1;
         return;
      end
      if (free_code < lim) begin
         dict_parent[free_code & DMASK] = last_code;
         dict_char[free_code & DMASK]   = tail;
         free_code++;
         if (free_code < lim && (free_code & (free_code - 1)) == 0) code_w++;
      end
      last_code = c;
      load_string(c);
   endfunction

   // Work out the response to one accepted request and advance the state
   function automatic rsp_item_type decode_step(logic is_pull, logic [7:0] data);
      rsp_item_type r;
      bit           done;
      int unsigned  take, c;
      r    = '0;
      done = emitted >= cfg_len;
      if (!is_pull) begin
         if (sticky_err) r.status = STAT_ERROR;
         else if (done) r.status = STAT_FINISHED;
         else if (pend_count != 0) r.status = STAT_REFUSED;
         else begin
            bitbuf |= data << bitcnt;
            bitcnt += 8;
            if (pad_bits != 0) begin
               take = pad_bits < bitcnt ? pad_bits : bitcnt;
               bitbuf >>= take;
               bitcnt -= take;
               pad_bits -= take;
            end
            if (pad_bits == 0 && bitcnt >= code_w) begin
               c = bitbuf & ((1 << code_w) - 1);
               bitbuf >>= code_w;
               bitcnt -= code_w;
               take_code(c);
            end
            bitbuf &= 24'hFFFFFF;
            r.status = STAT_TAKEN;
         end
         return r;
      end
      if (pend_count != 0 && !done) begin
         pend_count--;
         r.out_byte = pend_stack[pend_count];
         emitted++;
         if (emitted >= cfg_len) pend_count = 0;
         r.status = STAT_BYTE;
         r.end_of_string = pend_count == 0;
         return r;
      end
      if (done) pend_count = 0;
      if (sticky_err) r.status = STAT_ERROR;
      else if (done) r.status = STAT_FINISHED;
      else r.status = STAT_NONE;
      return r;
   endfunction

   // Request driver: valid stays high across back-to-back beats
   task automatic send_req(input logic is_pull, input logic [7:0] data,
                           input bit typed, input rsp_item_type typed_rsp,
                           output rsp_item_type got);
      rsp_item_type p;
      int unsigned  gap;
      if (n_items >= N_ITEMS - 150) quiet = 1;
      if (!quiet && $urandom_range(0, 11) == 0) begin
         gap = $urandom_range(1, 17);
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.opcode    <= is_pull;
      req_ch.data_byte <= data;
      do @(posedge clock); while (!req_ch.ready);
      p = decode_step(is_pull, data);
      got = typed ? typed_rsp : p;
      rsp_expected.push_back(got);
      n_items++;
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (rsp_expected.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [30:0] val);
      wait_idle();
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= val;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      apply_csr(idx, val);
      n_cfg++;
      @(posedge clock);
   endtask

   // LSB-first code packer
   logic [63:0] pack_acc;
   int unsigned pack_n;
   logic [7:0]  stream_bytes [$];

   task automatic pack_bits(input int unsigned val, input int unsigned w);
      pack_acc |= 64'(val) << pack_n;
      pack_n += w;
      while (pack_n >= 8) begin
         stream_bytes.push_back(pack_acc[7:0]);
         pack_acc >>= 8;
         pack_n -= 8;
      end
   endtask

   // Build a code stream, well-formed unless with_err adds an undefined code, mirroring the decoder's width growth
   task automatic build_stream(input int unsigned n_codes, input bit with_err);
      int unsigned nf, w, pos, lim, c, k, r, err_at;
      bit          pv;
      stream_bytes.delete();
      pack_acc = '0; pack_n = 0;
      nf = CLEAR_CODE + cfg_block; w = START_WIDTH; pos = 0; pv = 0;
      lim = table_limit();
      err_at = with_err ? $urandom_range(0, n_codes - 1) : n_codes;
      for (k = 0; k < n_codes; k++) begin
         r = $urandom_range(0, 99);
         if (k == err_at) begin
            // undefined code: at or beyond the next free entry
            c = pv ? nf + 1 : nf;
            if (c >= (1 << w)) c = (1 << w) - 1;
            if (c == CLEAR_CODE && cfg_block != 0) c = nf + 1;
            pack_bits(c, w);
            break;
         end
         if (cfg_block != 0 && r < 5) c = CLEAR_CODE;
         else if (!pv || r < 30) c = $urandom_range(0, 255);
         else if (r < 45 && nf < lim) c = nf;
         else if (nf > CLEAR_CODE + cfg_block) c = $urandom_range(CLEAR_CODE + cfg_block, nf - 1);
         else c = $urandom_range(0, 255);
         pack_bits(c, w);
         pos = (pos + 1) & 7;
         if (cfg_block != 0 && c == CLEAR_CODE) begin
            if (pos != 0) pack_bits(0, w * (8 - pos));
            nf = CLEAR_CODE + cfg_block; w = START_WIDTH; pos = 0; pv = 0;
         end else if (!pv) pv = 1;
         else if (nf < lim) begin
            nf++;
            if (nf < lim && (nf & (nf - 1)) == 0) w++;
         end
      end
      if (pack_n != 0) pack_bits($urandom_range(0, 255), 8 - pack_n);
   endtask

   // Feed a byte stream, pulling output as it becomes pending
   task automatic run_stream();
      rsp_item_type got;
      int unsigned  idx;
      idx = 0;
      while (idx < stream_bytes.size()) begin
         if (pend_count != 0 && emitted < cfg_len && $urandom_range(0, 9) != 0)
            send_req(OP_PULL, $urandom_range(0, 255), 0, '0, got);
         else if (pend_count == 0 && $urandom_range(0, 19) == 0)
            send_req(OP_PULL, $urandom_range(0, 255), 0, '0, got);
         else begin
            send_req(OP_PUSH, stream_bytes[idx], 0, '0, got);
            if (got.status == STAT_TAKEN) idx++;
            else if (got.status != STAT_REFUSED) break;
         end
      end
      do send_req(OP_PULL, 8'h00, 0, '0, got); while (got.status == STAT_BYTE);
      n_streams++;
   endtask

   typedef struct {
      bit           is_csr;
      logic [1:0]   sel;
      logic [30:0]  val;
      bit           typed;
      rsp_item_type rsp;
   } dir_row_type;

   localparam int N_DIR = 26;
   dir_row_type dir_rows [N_DIR];

   initial begin
      dir_rows = '{
         '{0, OP_PULL, 0,    1, '{STAT_FINISHED, 8'h00, 1'b0}},
         '{0, OP_PUSH, 0,    1, '{STAT_FINISHED, 8'h00, 1'b0}},
         '{1, REG_OUT_LEN, LEN_MAX, 0, '0},
         '{0, OP_PULL, 0,    1, '{STAT_NONE, 8'h00, 1'b0}},
         '{0, OP_PUSH, 'h41, 1, '{STAT_TAKEN, 8'h00, 1'b0}},
         '{0, OP_PUSH, 'h00, 1, '{STAT_TAKEN, 8'h00, 1'b0}},
         '{0, OP_PUSH, 'h55, 1, '{STAT_REFUSED, 8'h00, 1'b0}},
         '{0, OP_PULL, 0,    1, '{STAT_BYTE, 8'h41, 1'b1}},
         '{0, OP_PULL, 0,    1, '{STAT_NONE, 8'h00, 1'b0}},
         '{0, OP_PUSH, 'hFF, 0, '0},
         '{0, OP_PUSH, 'h12, 1, '{STAT_ERROR, 8'h00, 1'b0}},
         '{0, OP_PULL, 0,    1, '{STAT_ERROR, 8'h00, 1'b0}},
         '{1, REG_MAX_BITS, 0, 0, '0},
         '{1, REG_BLOCK_MODE, 0, 0, '0},
         '{1, REG_OUT_LEN, 1, 0, '0},
         '{0, OP_PUSH, 'h7A, 0, '0},
         '{0, OP_PUSH, 'h00, 0, '0},
         '{0, OP_PULL, 0,    1, '{STAT_BYTE, 8'h7A, 1'b1}},
         '{0, OP_PULL, 0,    1, '{STAT_FINISHED, 8'h00, 1'b0}},
         '{0, OP_PUSH, 'hAB, 1, '{STAT_FINISHED, 8'h00, 1'b0}},
         '{1, REG_BLOCK_MODE, 1, 0, '0},
         '{1, REG_MAX_BITS, 15, 0, '0},
         '{1, REG_OUT_LEN, LEN_MAX, 0, '0},
         '{0, OP_PUSH, 'h00, 0, '0},
         '{0, OP_PUSH, 'h01, 0, '0},
         '{0, OP_PUSH, 'hFF, 0, '0}
      };
   end

   // Response ready with random stall bursts
   int unsigned rsp_stall;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_stall = 0;
      end else if (rsp_stall != 0) begin
         rsp_stall--;
         rsp_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 13) == 0) begin
         rsp_stall = $urandom_range(0, 16);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Compare each response beat with the oldest expectation
   always @(posedge clock) begin
      rsp_item_type exp_r, act_r;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         act_r = '{rsp_ch.status, rsp_ch.out_byte, rsp_ch.end_of_string};
         n_beats++;
         if (rsp_expected.size() == 0) begin
            n_fail++;
            if (n_fail <= 10) $display("unexpected response beat: %p", act_r);
         end else begin
            exp_r = rsp_expected.pop_front();
            if (act_r.status == STAT_BYTE) n_bytes_out++;
            if (act_r.status != exp_r.status || act_r.out_byte != exp_r.out_byte ||
                act_r.end_of_string != exp_r.end_of_string) begin
               n_fail++;
               if (n_fail <= 10)
                  $display("mismatch at beat %0d: exp st=%0d byte=%h eos=%b, got st=%0d byte=%h eos=%b",
                           n_beats, exp_r.status, exp_r.out_byte, exp_r.end_of_string,
                           act_r.status, act_r.out_byte, act_r.end_of_string);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYC_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("tb NOT OK");
         $finish;
      end
   end

   initial begin
      rsp_item_type got;
      int unsigned  k, sel;
      logic [3:0]   bits_opts [8];
      bits_opts = '{4'd0, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15};
      req_ch.valid = 1'b0; req_ch.opcode = OP_PUSH; req_ch.data_byte = '0;
      csr_ch.valid = 1'b0; csr_ch.index = REG_MAX_BITS; csr_ch.data = '0;
      cycles = 0; n_items = 0; n_beats = 0; n_fail = 0; n_cfg = 0;
      n_streams = 0; n_bytes_out = 0; quiet = 0;
      cfg_bits = 14; cfg_block = 1; cfg_len = 0;
      stream_restart();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table
      for (k = 0; k < N_DIR; k++) begin
         if (dir_rows[k].is_csr) write_csr(dir_rows[k].sel, dir_rows[k].val);
         else send_req(dir_rows[k].sel[0], dir_rows[k].val[7:0], dir_rows[k].typed,
                       dir_rows[k].rsp, got);
      end

      // Fill the smallest dictionary to its limit once
      write_csr(REG_MAX_BITS, 31'd9);
      write_csr(REG_BLOCK_MODE, 31'd0);
      write_csr(REG_OUT_LEN, LEN_MAX);
      build_stream(290, 0);
      run_stream();

      // Random streams over changing settings
      while (n_items < N_ITEMS) begin
         if (n_items > N_ITEMS - 150) quiet = 1;
         sel = $urandom_range(0, 7);
         write_csr(REG_BLOCK_MODE, 31'($urandom_range(0, 1)));
         write_csr(REG_MAX_BITS, 31'(bits_opts[sel]));
         if ($urandom_range(0, 6) == 0) write_csr(REG_OUT_LEN, 31'($urandom_range(1, 40)));
         else write_csr(REG_OUT_LEN, LEN_MAX);
         if ($urandom_range(0, 9) == 0) begin
            stream_bytes.delete();
            repeat ($urandom_range(2, 12)) stream_bytes.push_back(8'($urandom_range(0, 255)));
         end else begin
            build_stream($urandom_range(8, 40), $urandom_range(0, 7) == 0);
         end
         run_stream();
      end

      req_ch.valid <= 1'b0;
      while (rsp_expected.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("covered %0d requests in %0d streams, %0d bytes decoded, %0d register writes",
               n_items, n_streams, n_bytes_out, n_cfg);
      if (n_fail == 0 && rsp_expected.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("%0d failures", n_fail);
         $display("tb NOT OK");
      end
      $finish;
   end
endmodule
